/* design/cfb_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the cuckoo filter bucket engine.
// No dependencies.
package cfb_pkg;

  // Fixed field widths
  localparam int REQ_W      = 2;
  localparam int KSLOT_W    = 5;
  localparam int TLEN_W     = 11;
  localparam int GCFG_W     = 4;
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Alternate index hash
  localparam int          PROD_W    = 32;
  localparam logic [31:0] ALT_MULT  = 32'h5bd1e995;
  localparam int          MOD_STEP  = 4;                  // remainder bits per cycle
  localparam int          MOD_CYC   = PROD_W / MOD_STEP;
  localparam int          MOD_CNT_W = $clog2(MOD_CYC);

  localparam logic [CNT_W-1:0] COUNT_MAX = 13'h1fff;

  // Register reset values
  localparam logic [TLEN_W-1:0] TLEN_RST = 11'd1024;
  localparam logic [GCFG_W-1:0] GCFG_RST = 4'd1;
  localparam logic [CNT_W-1:0]  CAP_RST  = 13'd4096;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_LENGTH = 2'd0,
    CFG_GROUP_SIZE   = 2'd1,
    CFG_CAPACITY     = 2'd2
  } cfg_idx_t;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_RMOD  = 9'b000001000,
    S_RD    = 9'b000010000,
    S_EXAM  = 9'b000100000,
    S_KICK  = 9'b001000000,
    S_VMOD  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

endpackage

/* design/cfb_req_if.sv */
`timescale 1ns / 1ps
// Request channel of the cuckoo filter bucket engine.
// Depends on cfb_pkg.
interface cfb_req_if
  import cfb_pkg::*;
#(
  parameter int IDX_W = 10,
  parameter int FP_W  = 12
) ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [IDX_W-1:0]   bucket_index;
  logic [FP_W-1:0]    fingerprint;
  logic               kickout;
  logic [KSLOT_W-1:0] kick_slot;

  modport source (output valid, req_type, bucket_index, fingerprint, kickout, kick_slot,
                  input ready);
  modport sink   (input valid, req_type, bucket_index, fingerprint, kickout, kick_slot,
                  output ready);
endinterface

/* design/cfb_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel of the cuckoo filter bucket engine.
// Depends on cfb_pkg.
interface cfb_rsp_if
  import cfb_pkg::*;
#(
  parameter int IDX_W = 10,
  parameter int FP_W  = 12
) ();
  logic             valid;
  logic             ready;
  logic             success;
  logic             victim_valid;
  logic [FP_W-1:0]  victim_fingerprint;
  logic [IDX_W-1:0] victim_alt_index;
  logic [IDX_W-1:0] req_alt_index;
  logic [CNT_W-1:0] item_count;
  logic             is_full;
  logic             is_vacant;
  logic             range_error;

  modport source (output valid, success, victim_valid, victim_fingerprint, victim_alt_index,
                         req_alt_index, item_count, is_full, is_vacant, range_error,
                  input ready);
  modport sink   (input valid, success, victim_valid, victim_fingerprint, victim_alt_index,
                        req_alt_index, item_count, is_full, is_vacant, range_error,
                  output ready);
endinterface

/* design/cfb_cfg_if.sv */
`timescale 1ns / 1ps
// Register write channel of the cuckoo filter bucket engine.
// Depends on cfb_pkg.
interface cfb_cfg_if
  import cfb_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/cfb_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cfb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/cuckoo_filter_bucket_engine.sv */
`timescale 1ns / 1ps
// Cuckoo filter bucket engine: top level, FSM, hash/modulo unit and row store.
// Depends on cfb_pkg, cfb_req_if, cfb_rsp_if, cfb_cfg_if, cfb_ram.

// Bucket store of a cuckoo filter. One RAM row holds one physical bucket of
// SLOTS_PER_BUCKET fingerprints; a logical bucket is group_size consecutive rows
// and a zero slot is empty. Requests are handled one at a time. From the input
// transfer a request passes through the hash multiply, the alternate-index
// remainder (a shared unit that retires 4 dividend bits per cycle), a RAM read
// then a compare and write-back for each row visited (at most G rows, G the
// effective group size), and a load of the output register, after which the
// idle state takes the next transfer. A rejected request visits no rows, and
// an insert that evicts a fingerprint adds a write of the kicked row plus the
// victim's remainder. The output register lets the next request be taken while
// a result waits. After reset a clearing pass zeroes the store, one row per
// cycle, during which no request is taken; register writes are taken at any
// time but must only be issued while the engine is idle.
module cuckoo_filter_bucket_engine
  import cfb_pkg::*;
#(
  parameter int NUM_BUCKETS      = 1024,
  parameter int FP_BITS          = 12,
  parameter int SLOTS_PER_BUCKET = 4,
  parameter int MAX_GROUP        = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  cfb_req_if.sink   in_req,
  cfb_rsp_if.source out_rsp,
  cfb_cfg_if.sink   cfg_wr
);

  localparam int IDX_W = $clog2(NUM_BUCKETS);
  localparam int ROW_W = FP_BITS * SLOTS_PER_BUCKET;
  localparam int GRP_W = $clog2(MAX_GROUP + 1);
  localparam int NS_W  = $clog2(MAX_GROUP * SLOTS_PER_BUCKET + 1);
  localparam int SL_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int BASE_W = IDX_W + GRP_W;
  localparam int END_W  = BASE_W + 1;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic [TLEN_W-1:0]   tlen_r, tlen_nxt;
  logic [GCFG_W-1:0]   gcfg_r, gcfg_nxt;
  logic [CNT_W-1:0]    cap_r, cap_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ov_r, ov_nxt;

  // request
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [FP_BITS-1:0]  fp_r, fp_nxt;
  logic                kick_r, kick_nxt;
  logic [KSLOT_W-1:0]  kslot_r, kslot_nxt;

  // work
  logic                err_r, err_nxt;
  logic [IDX_W-1:0]    base_r, base_nxt;
  logic [NS_W-1:0]     kj_r, kj_nxt;
  logic [GRP_W-1:0]    k_r, k_nxt;
  logic [NS_W-1:0]     pos_r, pos_nxt;
  logic [IDX_W-1:0]    krow_r, krow_nxt;
  logic [SL_W-1:0]     ksl_r, ksl_nxt;
  logic [ROW_W-1:0]    kdata_r, kdata_nxt;
  logic [PROD_W-1:0]   mod_x_r, mod_x_nxt;
  logic [TLEN_W-1:0]   rem_r, rem_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_r, mod_cnt_nxt;
  logic                succ_r, succ_nxt;
  logic                vvalid_r, vvalid_nxt;
  logic [FP_BITS-1:0]  vfp_r, vfp_nxt;
  logic [IDX_W-1:0]    valt_r, valt_nxt;
  logic [IDX_W-1:0]    ralt_r, ralt_nxt;

  // output register
  logic                o_succ_r, o_succ_nxt;
  logic                o_vvalid_r, o_vvalid_nxt;
  logic [FP_BITS-1:0]  o_vfp_r, o_vfp_nxt;
  logic [IDX_W-1:0]    o_valt_r, o_valt_nxt;
  logic [IDX_W-1:0]    o_ralt_r, o_ralt_nxt;
  logic [CNT_W-1:0]    o_count_r, o_count_nxt;
  logic                o_full_r, o_full_nxt;
  logic                o_empty_r, o_empty_nxt;
  logic                o_rerr_r, o_rerr_nxt;

  // ---------------------------------------------------------------------------
  // Row store
  // ---------------------------------------------------------------------------
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [ROW_W-1:0] mem_rdata;

  cfb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Effective register values (zero and oversize clamp)
  // ---------------------------------------------------------------------------
  logic [TLEN_W-1:0] eff_t;
  logic [GRP_W-1:0]  eff_g;
  logic [NS_W-1:0]   nslots;

  always_comb begin
    if (tlen_r == '0) begin
      eff_t = TLEN_W'(1);
    end else if (32'(tlen_r) > NUM_BUCKETS) begin
      eff_t = TLEN_W'(NUM_BUCKETS);
    end else begin
      eff_t = tlen_r;
    end
    if (gcfg_r == '0) begin
      eff_g = GRP_W'(1);
    end else if (32'(gcfg_r) > MAX_GROUP) begin
      eff_g = GRP_W'(MAX_GROUP);
    end else begin
      eff_g = GRP_W'(gcfg_r);
    end
    nslots = NS_W'(32'(eff_g) * SLOTS_PER_BUCKET);
  end

  // ---------------------------------------------------------------------------
  // Shared hash multiplier: request fingerprint, or the victim in S_KICK
  // ---------------------------------------------------------------------------
  logic [FP_BITS-1:0] mul_a;
  logic [PROD_W-1:0]  mul_p;
  logic [FP_BITS-1:0] kick_fp;

  assign mul_a = (state_r == S_KICK) ? kick_fp : fp_r;
  assign mul_p = PROD_W'(PROD_W'(mul_a) * ALT_MULT);

  // Remainder unit: MOD_STEP restoring steps per cycle against eff_t
  logic [TLEN_W-1:0] rem_t;
  logic [PROD_W-1:0] mx_t;
  logic [TLEN_W:0]   msh_t;
  logic              mod_last;

  always_comb begin
    rem_t = rem_r;
    mx_t  = mod_x_r;
    for (int s = 0; s < MOD_STEP; s++) begin
      msh_t = {rem_t, mx_t[PROD_W-1]};
      mx_t  = mx_t << 1;
      if (msh_t >= {1'b0, eff_t}) begin
        msh_t = msh_t - {1'b0, eff_t};
      end
      rem_t = msh_t[TLEN_W-1:0];
    end
  end

  assign mod_last = (mod_cnt_r == MOD_CNT_W'(MOD_CYC - 1));

  // Range check, group base and eviction slot (kick_slot mod slot count)
  logic [BASE_W-1:0] base_full;
  logic [END_W-1:0]  grp_end;
  logic              err_c;
  logic [NS_W-1:0]   kj_t;
  logic [NS_W:0]     ksh_t;

  always_comb begin
    base_full = BASE_W'(idx_r) * BASE_W'(eff_g);
    grp_end   = END_W'(base_full) + END_W'(eff_g);
    err_c     = (req_r != REQ_NONE) &&
                ((32'(idx_r) >= 32'(eff_t)) || (grp_end > END_W'(NUM_BUCKETS)) ||
                 (fp_r == '0));
    kj_t = '0;
    for (int b = KSLOT_W - 1; b >= 0; b--) begin
      ksh_t = {kj_t, kslot_r[b]};
      if (ksh_t >= {1'b0, nslots}) begin
        ksh_t = ksh_t - {1'b0, nslots};
      end
      kj_t = ksh_t[NS_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Row examine: first empty slot (insert) or first match (lookup, delete)
  // ---------------------------------------------------------------------------
  logic             hit;
  logic [SL_W-1:0]  hit_slot;
  logic [ROW_W-1:0] row_upd;
  logic             kick_here;
  logic             last_row;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      if ((req_r == REQ_INSERT) ? (mem_rdata[s*FP_BITS +: FP_BITS] == '0)
                                : (mem_rdata[s*FP_BITS +: FP_BITS] == fp_r)) begin
        hit      = 1'b1;
        hit_slot = SL_W'(s);
      end
    end
    row_upd = mem_rdata;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (SL_W'(s) == hit_slot) begin
        row_upd[s*FP_BITS +: FP_BITS] = (req_r == REQ_INSERT) ? fp_r : '0;
      end
    end
  end

  assign kick_here = ({1'b0, kj_r} >= {1'b0, pos_r}) &&
                     ({1'b0, kj_r} < ({1'b0, pos_r} + (NS_W+1)'(SLOTS_PER_BUCKET)));
  assign last_row  = (GRP_W'(k_r + GRP_W'(1)) == eff_g);

  // Eviction: take out slot ksl_r of the saved row, put the new fingerprint in
  logic [ROW_W-1:0] kick_row;

  always_comb begin
    kick_fp  = '0;
    kick_row = kdata_r;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (SL_W'(s) == ksl_r) begin
        kick_fp                        = kdata_r[s*FP_BITS +: FP_BITS];
        kick_row[s*FP_BITS +: FP_BITS] = fp_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic in_xfer;
  logic out_free;

  assign in_xfer  = in_req.valid && (state_r == S_IDLE);
  assign out_free = !ov_r || out_rsp.ready;

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    tlen_nxt    = tlen_r;
    gcfg_nxt    = gcfg_r;
    cap_nxt     = cap_r;
    count_nxt   = count_r;
    ov_nxt      = ov_r;
    req_nxt     = req_r;
    idx_nxt     = idx_r;
    fp_nxt      = fp_r;
    kick_nxt    = kick_r;
    kslot_nxt   = kslot_r;
    err_nxt     = err_r;
    base_nxt    = base_r;
    kj_nxt      = kj_r;
    k_nxt       = k_r;
    pos_nxt     = pos_r;
    krow_nxt    = krow_r;
    ksl_nxt     = ksl_r;
    kdata_nxt   = kdata_r;
    mod_x_nxt   = mod_x_r;
    rem_nxt     = rem_r;
    mod_cnt_nxt = mod_cnt_r;
    succ_nxt    = succ_r;
    vvalid_nxt  = vvalid_r;
    vfp_nxt     = vfp_r;
    valt_nxt    = valt_r;
    ralt_nxt    = ralt_r;
    o_succ_nxt   = o_succ_r;
    o_vvalid_nxt = o_vvalid_r;
    o_vfp_nxt    = o_vfp_r;
    o_valt_nxt   = o_valt_r;
    o_ralt_nxt   = o_ralt_r;
    o_count_nxt  = o_count_r;
    o_full_nxt   = o_full_r;
    o_empty_nxt  = o_empty_r;
    o_rerr_nxt   = o_rerr_r;
    mem_we    = 1'b0;
    mem_waddr = base_r + IDX_W'(k_r);
    mem_wdata = row_upd;
    mem_raddr = base_r + IDX_W'(k_r);

    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_TABLE_LENGTH: tlen_nxt = cfg_wr.data[TLEN_W-1:0];
        CFG_GROUP_SIZE:   gcfg_nxt = cfg_wr.data[GCFG_W-1:0];
        CFG_CAPACITY:     cap_nxt  = cfg_wr.data[CNT_W-1:0];
        default: ;
      endcase
    end

    if (ov_r && out_rsp.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(NUM_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt    = in_req.req_type;
          idx_nxt    = in_req.bucket_index;
          fp_nxt     = in_req.fingerprint;
          kick_nxt   = in_req.kickout;
          kslot_nxt  = in_req.kick_slot;
          succ_nxt   = 1'b0;
          vvalid_nxt = 1'b0;
          vfp_nxt    = '0;
          valt_nxt   = '0;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        err_nxt     = err_c;
        base_nxt    = IDX_W'(base_full);
        kj_nxt      = kj_t;
        mod_x_nxt   = PROD_W'(idx_r) ^ mul_p;
        rem_nxt     = '0;
        mod_cnt_nxt = '0;
        state_nxt   = S_RMOD;
      end
      S_RMOD: begin
        mod_x_nxt   = mx_t;
        rem_nxt     = rem_t;
        mod_cnt_nxt = mod_cnt_r + MOD_CNT_W'(1);
        if (mod_last) begin
          ralt_nxt = IDX_W'(rem_t);
          k_nxt    = '0;
          pos_nxt  = '0;
          if (err_r || (req_r == REQ_NONE)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EXAM;
      end
      S_EXAM: begin
        if (kick_here) begin
          krow_nxt  = base_r + IDX_W'(k_r);
          ksl_nxt   = SL_W'(kj_r - pos_r);
          kdata_nxt = mem_rdata;
        end
        if (hit) begin
          succ_nxt  = 1'b1;
          state_nxt = S_DONE;
          if (req_r == REQ_INSERT) begin
            mem_we = 1'b1;
            if (count_r < COUNT_MAX) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (req_r == REQ_DELETE) begin
            mem_we = 1'b1;
            if (count_r != '0) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end else if (last_row) begin
          if ((req_r == REQ_INSERT) && kick_r) begin
            state_nxt = S_KICK;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          k_nxt     = k_r + GRP_W'(1);
          pos_nxt   = pos_r + NS_W'(SLOTS_PER_BUCKET);
          state_nxt = S_RD;
        end
      end
      S_KICK: begin
        mem_we      = 1'b1;
        mem_waddr   = krow_r;
        mem_wdata   = kick_row;
        vvalid_nxt  = 1'b1;
        vfp_nxt     = kick_fp;
        mod_x_nxt   = PROD_W'(idx_r) ^ mul_p;
        rem_nxt     = '0;
        mod_cnt_nxt = '0;
        state_nxt   = S_VMOD;
      end
      S_VMOD: begin
        mod_x_nxt   = mx_t;
        rem_nxt     = rem_t;
        mod_cnt_nxt = mod_cnt_r + MOD_CNT_W'(1);
        if (mod_last) begin
          valt_nxt  = IDX_W'(rem_t);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          o_succ_nxt   = succ_r;
          o_vvalid_nxt = vvalid_r;
          o_vfp_nxt    = vfp_r;
          o_valt_nxt   = valt_r;
          o_ralt_nxt   = ralt_r;
          o_count_nxt  = count_r;
          o_full_nxt   = (count_r >= cap_r);
          o_empty_nxt  = (count_r == '0);
          o_rerr_nxt   = err_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      tlen_r  <= TLEN_RST;
      gcfg_r  <= GCFG_RST;
      cap_r   <= CAP_RST;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      tlen_r  <= tlen_nxt;
      gcfg_r  <= gcfg_nxt;
      cap_r   <= cap_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    fp_r       <= fp_nxt;
    kick_r     <= kick_nxt;
    kslot_r    <= kslot_nxt;
    err_r      <= err_nxt;
    base_r     <= base_nxt;
    kj_r       <= kj_nxt;
    k_r        <= k_nxt;
    pos_r      <= pos_nxt;
    krow_r     <= krow_nxt;
    ksl_r      <= ksl_nxt;
    kdata_r    <= kdata_nxt;
    mod_x_r    <= mod_x_nxt;
    rem_r      <= rem_nxt;
    mod_cnt_r  <= mod_cnt_nxt;
    succ_r     <= succ_nxt;
    vvalid_r   <= vvalid_nxt;
    vfp_r      <= vfp_nxt;
    valt_r     <= valt_nxt;
    ralt_r     <= ralt_nxt;
    o_succ_r   <= o_succ_nxt;
    o_vvalid_r <= o_vvalid_nxt;
    o_vfp_r    <= o_vfp_nxt;
    o_valt_r   <= o_valt_nxt;
    o_ralt_r   <= o_ralt_nxt;
    o_count_r  <= o_count_nxt;
    o_full_r   <= o_full_nxt;
    o_empty_r  <= o_empty_nxt;
    o_rerr_r   <= o_rerr_nxt;
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign in_req.ready = (state_r == S_IDLE);
  assign cfg_wr.ready = 1'b1;

  assign out_rsp.valid              = ov_r;
  assign out_rsp.success            = o_succ_r;
  assign out_rsp.victim_valid       = o_vvalid_r;
  assign out_rsp.victim_fingerprint = o_vfp_r;
  assign out_rsp.victim_alt_index   = o_valt_r;
  assign out_rsp.req_alt_index      = o_ralt_r;
  assign out_rsp.item_count         = o_count_r;
  assign out_rsp.is_full            = o_full_r;
  assign out_rsp.is_vacant          = o_empty_r;
  assign out_rsp.range_error        = o_rerr_r;

`ifndef SYNTHESIS
  // Store is only written by the clearing pass, a row update or an eviction.
  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR) || (state_r == S_EXAM) || (state_r == S_KICK))
    else $error("store written outside clear/examine/kick");

  // Rejected requests never reach the row walk.
  a_err_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RD) || (state_r == S_EXAM) || (state_r == S_KICK)) |-> !err_r)
    else $error("row walk on a rejected request");

  // Item count moves only on a row update.
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXAM) |=> $stable(count_r))
    else $error("item count changed outside row examine");

  // An eviction is never reported as a placement or with a range error.
  a_victim_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_vvalid_r) |-> (!o_succ_r && !o_rerr_r))
    else $error("victim reported together with success or range error");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for cuckoo_filter_bucket_engine: directed and random
// insert/lookup/delete traffic with a slot-level predictor and an in-order scoreboard.
// Depends on cfb_pkg, cfb_req_if, cfb_rsp_if, cfb_cfg_if and the engine itself.
module testbench
  import cfb_pkg::*;
();

  localparam int NUM_BUCKETS = 1024;
  localparam int SLOTS       = 4;
  localparam int MAX_GROUP   = 8;
  localparam int IDX_W       = 10;
  localparam int FP_W        = 12;
  localparam int STORE_DEPTH = NUM_BUCKETS * SLOTS;
  // Settle time after the last owed response, longer than the worst request.
  localparam int SETTLE      = 48;
  localparam int CYCLE_LIMIT = 1000000;
  // Register index with no register behind it; a write there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    req_type_t          rtype;
    logic [IDX_W-1:0]   idx;
    logic [FP_W-1:0]    fp;
    logic               kick;
    logic [KSLOT_W-1:0] kslot;
  } filter_req_t;

  typedef struct packed {
    logic             success;
    logic             victim_valid;
    logic [FP_W-1:0]  victim_fp;
    logic [IDX_W-1:0] victim_alt;
    logic [IDX_W-1:0] req_alt;
    logic [CNT_W-1:0] item_count;
    logic             is_full;
    logic             is_vacant;
    logic             range_error;
  } filter_rsp_t;

  // Mirror of the bucket store plus the queue of responses still owed by the engine.
  class filter_tracker;
    logic [FP_W-1:0]   slots [STORE_DEPTH];
    logic [CNT_W-1:0]  count;
    logic [TLEN_W-1:0] tlen;
    logic [GCFG_W-1:0] gsz;
    logic [CNT_W-1:0]  cap;
    filter_rsp_t       owed_rsps [$];
    int errors, reported, requests, placed, evicted, hits, removed, rejected;

    function new();
      foreach (slots[i]) slots[i] = '0;
      count    = '0;
      tlen     = TLEN_RST;
      gsz      = GCFG_RST;
      cap      = CAP_RST;
      errors   = 0;
      reported = 0;
      requests = 0;
      placed   = 0;
      evicted  = 0;
      hits     = 0;
      removed  = 0;
      rejected = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TABLE_LENGTH: tlen = data[TLEN_W-1:0];
        CFG_GROUP_SIZE:   gsz  = data[GCFG_W-1:0];
        CFG_CAPACITY:     cap  = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Odd register values clamp into the legal range.
    function int unsigned table_eff();
      if (tlen == 0) return 1;
      if (tlen > NUM_BUCKETS) return NUM_BUCKETS;
      return tlen;
    endfunction

    function int unsigned group_eff();
      if (gsz == 0) return 1;
      if (gsz > MAX_GROUP) return MAX_GROUP;
      return gsz;
    endfunction

    function logic [IDX_W-1:0] alt_of(int unsigned idx, int unsigned fp);
      logic [31:0] prod;
      prod = fp * ALT_MULT;
      return IDX_W'((idx ^ prod) % table_eff());
    endfunction

    function void note_request(filter_req_t r);
      int unsigned g, nslots, base, j;
      filter_rsp_t e;
      bit done;
      g      = group_eff();
      nslots = g * SLOTS;
      e      = '0;
      done   = 1'b0;
      requests++;
      e.req_alt = alt_of(r.idx, r.fp);
      if (r.rtype != REQ_NONE)
        e.range_error = (int'(r.idx) >= table_eff()) ||
                        ((int'(r.idx) + 1) * g > NUM_BUCKETS) || (r.fp == 0);
      if (e.range_error) rejected++;
      if (r.rtype != REQ_NONE && !e.range_error) begin
        base = int'(r.idx) * nslots;
        case (r.rtype)
          REQ_INSERT: begin
            for (int i = 0; i < nslots && !done; i++)
              if (slots[base + i] == 0) begin
                slots[base + i] = r.fp;
                done = 1'b1;
                if (count < COUNT_MAX) count++;
              end
            if (done) begin
              placed++;
            end else if (r.kick) begin
              // group full: swap into the chosen slot, hand the old one back
              j              = r.kslot % nslots;
              e.victim_fp    = slots[base + j];
              slots[base + j] = r.fp;
              e.victim_valid = 1'b1;
              e.victim_alt   = alt_of(r.idx, e.victim_fp);
              evicted++;
            end
          end
          REQ_LOOKUP: begin
            for (int i = 0; i < nslots && !done; i++)
              if (slots[base + i] == r.fp) done = 1'b1;
            if (done) hits++;
          end
          REQ_DELETE: begin
            for (int i = 0; i < nslots && !done; i++)
              if (slots[base + i] == r.fp) begin
                slots[base + i] = '0;
                done = 1'b1;
                if (count > 0) count--;
              end
            if (done) removed++;
          end
          default: ;
        endcase
        e.success = done;
      end
      e.item_count = count;
      e.is_full    = (count >= cap);
      e.is_vacant  = (count == 0);
      owed_rsps.push_back(e);
    endfunction

    function string describe(filter_rsp_t r);
      return $sformatf({"ok=%0b vv=%0b vfp=%03h valt=%0d ralt=%0d cnt=%0d",
                        " full=%0b vacant=%0b rerr=%0b"},
                       r.success, r.victim_valid, r.victim_fp, r.victim_alt, r.req_alt,
                       r.item_count, r.is_full, r.is_vacant, r.range_error);
    endfunction

    function void check_result(filter_rsp_t got);
      filter_rsp_t want;
      if (owed_rsps.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected response: %s", describe(got));
        end
        return;
      end
      want = owed_rsps.pop_front();
      if (got !== want) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("response mismatch at %0t", $realtime);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction

    function int pending();
      return owed_rsps.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cfb_req_if #(.IDX_W(IDX_W), .FP_W(FP_W)) req_ch ();
  cfb_rsp_if #(.IDX_W(IDX_W), .FP_W(FP_W)) rsp_ch ();
  cfb_cfg_if cfg_ch ();

  cuckoo_filter_bucket_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch),
    .cfg_wr (cfg_ch)
  );

  filter_tracker sb;

  // Random traffic shaping, refreshed per register setting
  int               in_range;
  int               burst_left;
  logic [IDX_W-1:0] idx_pool [6];
  logic [FP_W-1:0]  fp_pool  [10];
  int               cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost response ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d responses outstanding",
               cycle_count, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Monitor. Sampling at the edge sees pre-edge values on both sides, so a
  // transfer here is exactly what the engine took. Responses are checked before
  // the request of the same edge is noted; the engine is never that fast anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        sb.check_result('{success:      rsp_ch.success,
                          victim_valid: rsp_ch.victim_valid,
                          victim_fp:    rsp_ch.victim_fingerprint,
                          victim_alt:   rsp_ch.victim_alt_index,
                          req_alt:      rsp_ch.req_alt_index,
                          item_count:   rsp_ch.item_count,
                          is_full:      rsp_ch.is_full,
                          is_vacant:    rsp_ch.is_vacant,
                          range_error:  rsp_ch.range_error});
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        sb.note_request('{rtype: req_type_t'(req_ch.req_type),
                          idx:   req_ch.bucket_index,
                          fp:    req_ch.fingerprint,
                          kick:  req_ch.kickout,
                          kslot: req_ch.kick_slot});
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
        sb.write_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  // Response sink: its own stall pattern, switching between always ready,
  // coin-flip ready and long stall runs.
  initial begin : rsp_sink
    int   mode;
    int   mode_left;
    int   run_left;
    logic level;
    rsp_ch.ready <= 1'b0;
    mode      = 0;
    mode_left = 0;
    run_left  = 0;
    level     = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (run_left == 0) begin
            level    = ~level;
            run_left = level ? $urandom_range(1, 6) : $urandom_range(5, 40);
          end
          run_left--;
          rsp_ch.ready <= level;
        end
      endcase
    end
  end

  function automatic filter_req_t request_of(req_type_t t, int idx, int fp, bit kick, int kslot);
    filter_req_t r;
    r.rtype = t;
    r.idx   = IDX_W'(idx);
    r.fp    = FP_W'(fp);
    r.kick  = kick;
    r.kslot = KSLOT_W'(kslot);
    return r;
  endfunction

  // Mostly hits on a small pool of buckets and fingerprints, so inserts fill
  // groups that later lookups and deletes find; the rest is noise.
  function automatic filter_req_t random_request();
    filter_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.rtype = REQ_INSERT;
    else if (pick < 70) r.rtype = REQ_LOOKUP;
    else if (pick < 94) r.rtype = REQ_DELETE;
    else                r.rtype = REQ_NONE;
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.idx = idx_pool[$urandom_range(0, 5)];
    else if (pick < 90) r.idx = IDX_W'($urandom_range(0, in_range - 1));
    else                r.idx = IDX_W'($urandom_range(0, NUM_BUCKETS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 5)       r.fp = '0;
    else if (pick < 60) r.fp = fp_pool[$urandom_range(0, 9)];
    else                r.fp = FP_W'($urandom_range(1, 4095));
    r.kick  = 1'($urandom_range(0, 1));
    r.kslot = KSLOT_W'($urandom_range(0, 31));
    return r;
  endfunction

  // Presents one request and returns at the edge of its transfer; valid stays
  // high so a following request can go back to back.
  task automatic drive_item(input filter_req_t r);
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.rtype;
    req_ch.bucket_index <= r.idx;
    req_ch.fingerprint  <= r.fp;
    req_ch.kickout      <= r.kick;
    req_ch.kick_slot    <= r.kslot;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Only called with n > 0, so valid never drops and rises in one step.
  task automatic hold_off(input int n);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 45)
                                               : $urandom_range(1, 8);
      hold_off(gap);
    end
  endtask

  // Stop sending until every owed response is back, then let the engine settle.
  // The extra edge lets the monitor note a transfer from the current edge first.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Program all registers, then rebuild the traffic pools for the new geometry.
  task automatic configure(input logic [CFG_DATA_W-1:0] tlen_val, input int g, input int cap_val);
    int t_eff, g_eff;
    write_reg(CFG_SPARE, 13'h1abc);
    write_reg(CFG_TABLE_LENGTH, tlen_val);
    write_reg(CFG_GROUP_SIZE, CFG_DATA_W'(g));
    write_reg(CFG_CAPACITY, CFG_DATA_W'(cap_val));
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    t_eff = tlen_val[TLEN_W-1:0];
    g_eff = g[GCFG_W-1:0];
    if (t_eff == 0) t_eff = 1;
    if (t_eff > NUM_BUCKETS) t_eff = NUM_BUCKETS;
    if (g_eff == 0) g_eff = 1;
    if (g_eff > MAX_GROUP) g_eff = MAX_GROUP;
    in_range = (t_eff < NUM_BUCKETS / g_eff) ? t_eff : NUM_BUCKETS / g_eff;
    foreach (idx_pool[i]) idx_pool[i] = IDX_W'($urandom_range(0, in_range - 1));
    foreach (fp_pool[i])  fp_pool[i]  = FP_W'($urandom_range(1, 4095));
  endtask

  // One register setting's worth of random traffic, with a full drain halfway.
  task automatic run_random(input int n);
    burst_left = $urandom_range(0, 20);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) wait_drained();
      drive_item(random_request());
      pace();
    end
  endtask

  initial begin
    sb          = new();
    cycle_count = 0;
    in_range    = NUM_BUCKETS;
    burst_left  = 0;
    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_NONE;
    req_ch.bucket_index <= '0;
    req_ch.fingerprint  <= '0;
    req_ch.kickout      <= 1'b0;
    req_ch.kick_slot    <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_TABLE_LENGTH;
    cfg_ch.data         <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset register values. The engine first clears its store;
    // the handshake simply waits that out.
    drive_item(request_of(REQ_INSERT, 0, 12'hfff, 1'b0, 0));
    drive_item(request_of(REQ_INSERT, 0, 1, 1'b0, 0));
    drive_item(request_of(REQ_INSERT, 0, 2, 1'b0, 0));
    drive_item(request_of(REQ_INSERT, 0, 3, 1'b0, 0));
    drive_item(request_of(REQ_INSERT, 0, 5, 1'b0, 7));    // full group, no kickout
    drive_item(request_of(REQ_INSERT, 0, 6, 1'b1, 31));   // evict, slot choice wraps
    drive_item(request_of(REQ_LOOKUP, 0, 12'hfff, 1'b0, 0));
    drive_item(request_of(REQ_LOOKUP, 0, 3, 1'b0, 0));    // evicted, must miss
    drive_item(request_of(REQ_DELETE, 0, 1, 1'b0, 0));
    drive_item(request_of(REQ_DELETE, 0, 1, 1'b0, 0));    // already gone
    drive_item(request_of(REQ_INSERT, 1023, 12'hfff, 1'b1, 0));
    drive_item(request_of(REQ_LOOKUP, 1023, 12'hfff, 1'b1, 31));
    drive_item(request_of(REQ_INSERT, 5, 0, 1'b1, 0));    // zero fingerprint
    drive_item(request_of(REQ_LOOKUP, 5, 0, 1'b0, 0));
    drive_item(request_of(REQ_NONE, 1023, 12'hfff, 1'b1, 31));
    drive_item(request_of(REQ_DELETE, 1023, 12'hfff, 1'b0, 0));
    drive_item(request_of(REQ_DELETE, 0, 12'hfff, 1'b0, 0));
    drive_item(request_of(REQ_DELETE, 0, 2, 1'b0, 0));
    drive_item(request_of(REQ_DELETE, 0, 6, 1'b0, 0));    // store now empty
    drive_item(request_of(REQ_DELETE, 0, 7, 1'b0, 0));    // counter floor
    drive_item(request_of(REQ_LOOKUP, 512, 12'haaa, 1'b1, 21));

    // Clamped registers: table length past the store, group past the limit,
    // capacity zero so the filter always reports full.
    wait_drained();
    configure(13'd2047, 15, 0);
    drive_item(request_of(REQ_INSERT, 127, 12'hfff, 1'b0, 0));  // last group that fits
    drive_item(request_of(REQ_INSERT, 128, 12'h001, 1'b0, 0));  // group reaches past store
    drive_item(request_of(REQ_LOOKUP, 127, 12'hfff, 1'b0, 0));
    drive_item(request_of(REQ_DELETE, 127, 12'hfff, 1'b0, 0));
    run_random(250);

    // Upper bits of the table length write are dropped: this lands as 16.
    wait_drained();
    configure(13'h1810, 1, 20);
    run_random(300);

    wait_drained();
    configure(13'd1024, 1, 4096);
    run_random(250);

    // Zero table length and zero group both act as one.
    wait_drained();
    configure(13'd0, 0, 8191);
    run_random(200);

    wait_drained();
    configure(13'd100, 8, 50);
    run_random(250);

    wait_drained();
    configure(13'd37, 3, 3);
    run_random(300);

    wait_drained();
    configure(13'd1, 1, 1);
    run_random(150);

    wait_drained();
    configure(13'd513, 2, 600);
    run_random(250);

    wait_drained();
    $display("%0d requests: %0d placed, %0d evictions, %0d lookup hits, %0d removed",
             sb.requests, sb.placed, sb.evicted, sb.hits, sb.removed);
    $display("%0d rejected; nine register settings incl. clamped and zero values; %0d bad",
             sb.rejected, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
